/* hdl/tcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Types, character codes and helpers shared by the text content classifier.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Result class codes
  typedef enum logic [2:0] {
    CLS_BINARY  = 3'd0,
    CLS_ASM     = 3'd1,
    CLS_NROFF   = 3'd2,
    CLS_CMDS    = 3'd3,
    CLS_YACC    = 3'd4,
    CLS_XMAIL   = 3'd5,
    CLS_C_PROG  = 3'd6,
    CLS_TEXT    = 3'd7
  } file_class_e;

  // Lookahead rule waiting on later bytes
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_DOT  = 2'd1,
    PEND_PCT  = 2'd2
  } pend_e;

  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSharp  = 8'h23;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBang   = 8'h21;

  localparam int unsigned  DotWordLen = 5;
  localparam logic [4:0]   PhaseLast  = 5'd21;  // position 22 of each group

  typedef struct packed {
    logic        at_line_start;
    logic [7:0]  byte_before;
    logic        early_found;
    file_class_e early_class;
    logic        seen_sharp_semi;
    logic        seen_brace;
    logic        xmail_flag;
    logic [4:0]  phase;
    logic        binary_seen;
    pend_e       pend;
    logic [2:0]  dot_cnt;     // letters of "globl" matched so far
    logic        dot_ls;      // pending dot stood at line start
  } tcc_state_t;

  localparam tcc_state_t StInit = '{
    at_line_start:   1'b1,
    byte_before:     8'h00,
    early_found:     1'b0,
    early_class:     CLS_BINARY,
    seen_sharp_semi: 1'b0,
    seen_brace:      1'b0,
    xmail_flag:      1'b0,
    phase:           5'd0,
    binary_seen:     1'b0,
    pend:            PEND_NONE,
    dot_cnt:         3'd0,
    dot_ls:          1'b0
  };

  // Printable 7-bit, whitespace, backspace or bell
  function automatic logic byte_is_text(input logic [7:0] c);
    byte_is_text = ((c >= 8'h20) && (c <= 8'h7E)) || ((c >= 8'h07) && (c <= 8'h0D));
  endfunction

  // Letters of "globl" after the dot
  function automatic logic [7:0] dot_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h67;  // g
      3'd1:    r = 8'h6C;  // l
      3'd2:    r = 8'h6F;  // o
      3'd3:    r = 8'h62;  // b
      3'd4:    r = 8'h6C;  // l
      default: r = 8'h00;
    endcase
    dot_char = r;
  endfunction

endpackage
`default_nettype wire

/* hdl/tcc_judge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_judge
// Per-byte rule update: takes the classifier state and one byte, gives the
// next state and the class the head would get if it ended here.
// ----------------------------------------------------------------------------
module tcc_judge (
  input  wire tcc_pkg::tcc_state_t state_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            take_i,      // byte lies inside the window
  input  wire logic            last_i,
  output tcc_pkg::tcc_state_t  state_o,
  output tcc_pkg::file_class_e file_class_o
);
  import tcc_pkg::*;

  tcc_state_t n;
  logic       fired;
  logic       skip;
  logic [7:0] c;

  always_comb begin
    n     = state_i;
    fired = 1'b0;
    skip  = 1'b0;
    c     = data_byte_i;

    if (take_i) begin
      if (!byte_is_text(c)) begin
        n.binary_seen = 1'b1;
      end
      if (!state_i.early_found) begin
        // resolve a rule started by an earlier byte
        case (state_i.pend)
          PEND_DOT: begin
            if (c == dot_char(state_i.dot_cnt)) begin
              if (state_i.dot_cnt == 3'(DotWordLen - 1)) begin
                n.early_class = CLS_ASM;
                n.pend        = PEND_NONE;
                fired         = 1'b1;
              end else begin
                n.dot_cnt = state_i.dot_cnt + 3'd1;
              end
            end else begin
              n.pend = PEND_NONE;
              if (state_i.dot_ls) begin
                n.early_class = CLS_NROFF;
                fired         = 1'b1;
              end
            end
          end
          PEND_PCT: begin
            n.pend = PEND_NONE;
            if ((c == ChPct) || (c == ChLBrace) || (c == ChRBrace)) begin
              n.early_class = CLS_YACC;
              fired         = 1'b1;
            end
          end
          default: ;
        endcase

        if (!fired) begin
          if (c == ChDot) begin
            n.pend    = PEND_DOT;
            n.dot_cnt = 3'd0;
            n.dot_ls  = state_i.at_line_start;
            // line-start dot ends as assembler or nroff either way
            skip      = state_i.at_line_start;
          end
          if (state_i.at_line_start) begin
            if (c == ChColon) begin
              n.early_class = CLS_CMDS;
              fired         = 1'b1;
            end else if (c == ChSharp) begin
              n.seen_sharp_semi = 1'b1;
            end else if (c == ChPct) begin
              n.pend = PEND_PCT;
            end
          end
          if (!fired && !skip) begin
            if ((c == ChLBrace) || (c == ChRBrace)) begin
              n.seen_brace = 1'b1;
            end
            if (c == ChNl) begin
              n.at_line_start = 1'b1;
              if (state_i.byte_before == ChSemi) begin
                n.seen_sharp_semi = 1'b1;
              end
              if (state_i.phase == PhaseLast) begin
                if ((state_i.byte_before == ChSpace) || (state_i.byte_before == ChBang)) begin
                  n.xmail_flag = 1'b1;
                end
              end else begin
                n.xmail_flag = 1'b0;
              end
            end else begin
              n.at_line_start = 1'b0;
            end
            n.phase       = (state_i.phase >= PhaseLast) ? 5'd0 : state_i.phase + 5'd1;
            n.byte_before = c;
          end
        end
        if (fired) begin
          n.early_found = 1'b1;
        end
      end
    end

    // end of head: a dot at line start without "globl" after it is nroff
    if (last_i && !n.early_found && (n.pend == PEND_DOT) && n.dot_ls) begin
      n.early_found = 1'b1;
      n.early_class = CLS_NROFF;
    end

    if (n.binary_seen) begin
      file_class_o = CLS_BINARY;
    end else if (n.early_found) begin
      file_class_o = n.early_class;
    end else if (n.xmail_flag) begin
      file_class_o = CLS_XMAIL;
    end else if (n.seen_sharp_semi && n.seen_brace) begin
      file_class_o = CLS_C_PROG;
    end else begin
      file_class_o = CLS_TEXT;
    end
    state_o = n;
  end

endmodule
`default_nettype wire

/* hdl/text_content_classifier_top.sv */
`default_nettype none
// Path: the byte marked last passes the input register, then the result
//   register, before its class is offered on the output.
// Throughput: one byte per cycle; the input stalls only while a finished class
//   waits in the result register and the next last byte is already staged.
// Reset: asynchronous, active low; clears all rule state, the byte count and
//   both valid flags. State also returns to reset values after each result.
// ----------------------------------------------------------------------------
// text_content_classifier_top
// Classifies a file head streamed one byte per item. Rules that need later
// bytes (".globl", line-start "%%", "%{" or "%}") are tracked as pending matches,
// so each byte is judged as it arrives and no lookahead buffer is needed.
// ----------------------------------------------------------------------------
module text_content_classifier_top #(
  parameter int unsigned WINDOW_BYTES = 512   // bytes that count, 8..65536
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output      logic       s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,   // last_byte
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o    // [2:0] file_class, [7:3] zero
);
  import tcc_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_BYTES + 1);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // rule state and window count
  tcc_state_t      st_q, st_d, st_next;
  logic [CntW-1:0] taken_q, taken_d;

  // result register
  logic        out_valid_q, out_valid_d;
  file_class_e out_class_q, cls;

  logic s_acc, advance, take;

  assign take = (taken_q < CntW'(WINDOW_BYTES));

  tcc_judge u_judge (
    .state_i      (st_q),
    .data_byte_i  (s1_byte_q),
    .take_i       (take),
    .last_i       (s1_last_q),
    .state_o      (st_next),
    .file_class_o (cls)
  );

  // staged byte moves on unless it is last and the result slot is still full
  assign advance = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d  = s_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    st_d        = st_q;
    taken_d     = taken_q;
    out_valid_d = (m_axis_tready_i) ? 1'b0 : out_valid_q;
    if (advance) begin
      if (s1_last_q) begin
        st_d        = StInit;
        taken_d     = '0;
        out_valid_d = 1'b1;
      end else begin
        st_d    = st_next;
        taken_d = taken_q + CntW'(take);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      st_q        <= StInit;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      st_q        <= st_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_byte_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
    if (advance && s1_last_q) begin
      out_class_q <= cls;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_class_q};

endmodule
`default_nettype wire

/* hdl/tcc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before taken");

  // stalled result keeps its class
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // input only stalls behind a result that waits to be taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // padding above the class is zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:3] == 5'd0)
    else $error("nonzero padding in result");

endmodule

bind text_content_classifier_top tcc_checker u_tcc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
